### hdl/qtta_pkg.sv
`timescale 1ns / 1ps
package qtta_pkg;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               gimbal_lock;
   } rsp_type;

   localparam int CordicSteps = 16;
   localparam int SqrtBits = 29;                 // result bits of sqrt(2^56 - c^2)
   localparam int QuotBits = 30;                 // clamped quotient magnitude bits
   localparam logic signed [31:0] OneQ28 = 32'sd268435456;
   localparam logic [56:0] OneQ56 = 57'h100_0000_0000_0000;
   localparam logic [56:0] LockMargin = 57'd72057594037;
   localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
   localparam logic signed [19:0] PiQ16 = 20'sd205887;
   localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

   function automatic logic signed [19:0] atan_entry(input logic [3:0] idx);
      logic signed [19:0] r;
      case (idx)
         4'd0:    r = 20'sd51472;
         4'd1:    r = 20'sd30386;
         4'd2:    r = 20'sd16055;
         4'd3:    r = 20'sd8150;
         4'd4:    r = 20'sd4091;
         4'd5:    r = 20'sd2047;
         4'd6:    r = 20'sd1024;
         4'd7:    r = 20'sd512;
         4'd8:    r = 20'sd256;
         4'd9:    r = 20'sd128;
         4'd10:   r = 20'sd64;
         4'd11:   r = 20'sd32;
         4'd12:   r = 20'sd16;
         4'd13:   r = 20'sd8;
         4'd14:   r = 20'sd4;
         default: r = 20'sd2;
      endcase
      return r;
   endfunction

endpackage

### hdl/quaternion_to_tilt_angles.sv
`timescale 1ns / 1ps
// A request passes through 113 pipeline stages and then the output queue before
// its response transfer.
// Throughput: one quaternion per cycle; every stage advances together under a global
// enable, which drops only while the two-entry output queue is full and stalled.
// Reset: synchronous, active high; clears all stage valid bits and the output queue.
// Payload registers are not reset.
module quaternion_to_tilt_angles
   import qtta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Stage plan (all stages advance on adv):
   //  P0  register input
   //  P1  products (8 x 16x16)
   //  P2  direction cosines and yaw numerator
   //  P3  clamps and squares c^2 (30x30, three: cxz, cyz, cxz again for lock)
   //  P4  radicands 2^56 - c^2, lock decision
   //  Q   29 sqrt stages, one result bit each (three roots in parallel)
   //  R   setup: yaw numerator scaled, roll/pitch CORDIC start vectors
   //  D   30 restoring divide stages (yaw ratio), one quotient bit each
   //  Y0  ratio clamp and sign, radicand 2^56 - ratio^2
   //  YS  29 sqrt stages for the yaw argument
   //  Y   yaw CORDIC start vector
   //  C   16 CORDIC stages for each of three angles
   //  F   final clamp/round and sign
   // Roll/pitch start vectors ride along so all three CORDIC lanes run together.

   localparam int NQ = SqrtBits;
   localparam int ND = QuotBits;
   localparam int NC = CordicSteps;

   // output queue
   logic [1:0] cnt_ff, cnt_in;
   rsp_type    q0_ff, q1_ff;
   logic       adv;
   logic       pipe_out_v;
   rsp_type    pipe_out;

   // Advance the whole pipeline when queue has room for the head item.
   assign adv = (cnt_ff != 2'd2) || !rsp_stall;
   // Hold requests while the queue is full and its head is stalled.
   assign req_stall = !adv;

   // ---------------- P0..P4 ----------------
   req_type p0_ff;
   logic signed [31:0] xz_ff, wy_ff, yz_ff, wx_ff, xy_ff, wz_ff, xx_ff, ww_ff;
   logic signed [33:0] cxz_ff, cyz_ff, cxy_ff, num_ff;
   logic signed [33:0] cxz2_ff, cxy2_ff, num2_ff;
   logic signed [29:0] cxzc2_ff, cyzc2_ff;
   logic [57:0] sq_xz_ff, sq_yz_ff, sq_lk_ff;
   logic signed [29:0] cxzc3_ff, cyzc3_ff;
   logic signed [33:0] cxy3_ff, num3_ff;
   logic [56:0] rad_xz_ff, rad_yz_ff, rad_lk_ff;
   logic        lock4_ff;

   function automatic logic signed [29:0] clamp30(input logic signed [33:0] c);
      if (c > 34'(OneQ28)) return 30'(OneQ28);
      if (c < -34'(OneQ28)) return -30'(OneQ28);
      return c[29:0];
   endfunction

   function automatic logic [57:0] square30(input logic signed [29:0] c);
      logic signed [59:0] p;
      p = c * c;
      return p[57:0];
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_ff <= req_data;
         xz_ff <= p0_ff.quat_x * p0_ff.quat_z;
         wy_ff <= p0_ff.quat_w * p0_ff.quat_y;
         yz_ff <= p0_ff.quat_y * p0_ff.quat_z;
         wx_ff <= p0_ff.quat_w * p0_ff.quat_x;
         xy_ff <= p0_ff.quat_x * p0_ff.quat_y;
         wz_ff <= p0_ff.quat_w * p0_ff.quat_z;
         xx_ff <= p0_ff.quat_x * p0_ff.quat_x;
         ww_ff <= p0_ff.quat_w * p0_ff.quat_w;
         // P2
         cxz_ff <= (34'(xz_ff) - 34'(wy_ff)) <<< 1;
         cyz_ff <= (34'(yz_ff) + 34'(wx_ff)) <<< 1;
         cxy_ff <= (34'(xy_ff) + 34'(wz_ff)) <<< 1;
         num_ff <= ((34'(xx_ff) + 34'(ww_ff)) <<< 1) - 34'(OneQ28);
         // P3
         cxzc2_ff <= clamp30(cxz_ff);
         cyzc2_ff <= clamp30(cyz_ff);
         cxz2_ff  <= cxz_ff;
         cxy2_ff  <= cxy_ff;
         num2_ff  <= num_ff;
         sq_xz_ff <= square30(clamp30(cxz_ff));
         sq_yz_ff <= square30(clamp30(cyz_ff));
         sq_lk_ff <= square30(clamp30(cxz_ff));
         // P4
         cxzc3_ff <= cxzc2_ff;
         cyzc3_ff <= cyzc2_ff;
         cxy3_ff  <= cxy2_ff;
         num3_ff  <= num2_ff;
         rad_xz_ff <= OneQ56 - sq_xz_ff[56:0];
         rad_yz_ff <= OneQ56 - sq_yz_ff[56:0];
         rad_lk_ff <= OneQ56 - sq_lk_ff[56:0];
         lock4_ff <= !(cxz2_ff < 34'(OneQ28) && cxz2_ff > -34'(OneQ28))
                     || ((OneQ56 - sq_lk_ff[56:0]) <= LockMargin);
      end
   end

   // ---------------- integer sqrt, one result bit per stage ----------------
   // Restoring method: rem/root, consuming two radicand bits per stage.
   logic [NQ-1:0] sr_ff [3][NQ+1];
   logic [NQ+1:0] sm_ff [3][NQ+1];
   logic [56:0]   sv_ff [3][NQ+1];
   logic signed [29:0] qa_ff [NQ+1], qb_ff [NQ+1];
   logic signed [33:0] qc_ff [NQ+1], qn_ff [NQ+1];
   logic               ql_ff [NQ+1];

   always_comb begin
      sv_ff[0][0] = rad_xz_ff;
      sv_ff[1][0] = rad_yz_ff;
      sv_ff[2][0] = rad_lk_ff;
      for (int k = 0; k < 3; k++) begin
         sr_ff[k][0] = '0;
         sm_ff[k][0] = '0;
      end
      qa_ff[0] = cxzc3_ff;
      qb_ff[0] = cyzc3_ff;
      qc_ff[0] = cxy3_ff;
      qn_ff[0] = num3_ff;
      ql_ff[0] = lock4_ff;
   end

   for (genvar s = 0; s < NQ; s++) begin : g_sqrt
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic [57:0]   rad58;
         logic [NQ+1:0] trial;
         logic [NQ+1:0] rem_sh;
         // Pad the radicand to an even bit count so the pairs line up.
         assign rad58  = {1'b0, sv_ff[k][s]};
         assign rem_sh = {sm_ff[k][s][NQ-1:0], rad58[57-2*s -: 2]};
         assign trial  = rem_sh - {sr_ff[k][s], 2'b01};
         always_ff @(posedge clock) begin
            if (adv) begin
               sv_ff[k][s+1] <= sv_ff[k][s];
               if (!trial[NQ+1]) begin
                  sm_ff[k][s+1] <= trial;
                  sr_ff[k][s+1] <= {sr_ff[k][s][NQ-2:0], 1'b1};
               end else begin
                  sm_ff[k][s+1] <= rem_sh;
                  sr_ff[k][s+1] <= {sr_ff[k][s][NQ-2:0], 1'b0};
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            qa_ff[s+1] <= qa_ff[s];
            qb_ff[s+1] <= qb_ff[s];
            qc_ff[s+1] <= qc_ff[s];
            qn_ff[s+1] <= qn_ff[s];
            ql_ff[s+1] <= ql_ff[s];
         end
      end
   end

   // ---------------- R: setup ----------------
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [19:0] z;
   } cvec_type;

   function automatic cvec_type cstart(input logic signed [29:0] c,
                                       input logic [NQ-1:0] s);
      cvec_type v;
      if (c < 0) begin
         v.x = 32'($unsigned(s));
         v.y = -32'(c);
         v.z = HalfPiQ16;
      end else begin
         v.x = 32'(c);
         v.y = 32'($unsigned(s));
         v.z = '0;
      end
      return v;
   endfunction

   cvec_type ra_ff, rb_ff;
   logic signed [33:0] rc_ff;
   logic               rl_ff;
   logic               rneg_ff;
   logic [63:0]        rnum_ff;   // |num| << 28
   logic [NQ-1:0]      rden_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_ff   <= cstart(qa_ff[NQ], sr_ff[0][NQ]);
         rb_ff   <= cstart(qb_ff[NQ], sr_ff[1][NQ]);
         rc_ff   <= qc_ff[NQ];
         rl_ff   <= ql_ff[NQ];
         rneg_ff <= qn_ff[NQ][33];
         rnum_ff <= 64'(qn_ff[NQ][33] ? -qn_ff[NQ] : qn_ff[NQ]) << 28;
         rden_ff <= (sr_ff[2][NQ] == '0) ? NQ'(1) : sr_ff[2][NQ];
      end
   end

   // ---------------- D: restoring divide, 30 quotient bits ----------------
   // Quotient is clamped at 2^28, so only the low 30 bits matter; high
   // bits are folded into a saturation flag computed up front.
   logic [63:0]     dn_ff  [ND+1];
   logic [NQ+ND:0]  dr_ff  [ND+1];
   logic [ND-1:0]   dq_ff  [ND+1];
   logic [NQ-1:0]   dd_ff  [ND+1];
   logic            dsat_ff[ND+1];
   logic            dneg_ff[ND+1];
   cvec_type        da_ff  [ND+1], db_ff [ND+1];
   logic signed [33:0] dc_ff [ND+1];
   logic            dl_ff  [ND+1];

   always_comb begin
      dn_ff[0]   = rnum_ff;
      dd_ff[0]   = rden_ff;
      dq_ff[0]   = '0;
      // saturate when num >= den * 2^ND
      dsat_ff[0] = (rnum_ff >> ND) >= 64'(rden_ff);
      dr_ff[0]   = (NQ+ND+1)'(rnum_ff >> ND) & {(NQ+ND+1){1'b0}};
      dneg_ff[0] = rneg_ff;
      da_ff[0]   = ra_ff;
      db_ff[0]   = rb_ff;
      dc_ff[0]   = rc_ff;
      dl_ff[0]   = rl_ff;
   end

   for (genvar s = 0; s < ND; s++) begin : g_div
      logic [NQ+ND:0] rem0, rem1;
      always_comb begin
         rem0 = (s == 0) ? (NQ+ND+1)'(dn_ff[s] >> ND) : dr_ff[s];
         rem1 = {rem0[NQ+ND-1:0], dn_ff[s][ND-1-s]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem1 >= (NQ+ND+1)'(dd_ff[s])) begin
               dr_ff[s+1] <= rem1 - (NQ+ND+1)'(dd_ff[s]);
               dq_ff[s+1] <= {dq_ff[s][ND-2:0], 1'b1};
            end else begin
               dr_ff[s+1] <= rem1;
               dq_ff[s+1] <= {dq_ff[s][ND-2:0], 1'b0};
            end
            dn_ff[s+1]   <= dn_ff[s];
            dd_ff[s+1]   <= dd_ff[s];
            dsat_ff[s+1] <= dsat_ff[s];
            dneg_ff[s+1] <= dneg_ff[s];
            da_ff[s+1]   <= da_ff[s];
            db_ff[s+1]   <= db_ff[s];
            dc_ff[s+1]   <= dc_ff[s];
            dl_ff[s+1]   <= dl_ff[s];
         end
      end
   end

   // ---------------- Y0: clamp the ratio, form its radicand ----------------
   cvec_type ya_ff, yb_ff, yy_ff;
   logic signed [33:0] yc_ff;
   logic               yl_ff;
   logic signed [29:0] ratio_c;
   logic [ND-1:0]      qmag;
   logic [NQ-1:0]      ysq;
   logic [57:0]        ratio_sq;

   always_comb begin
      qmag = dq_ff[ND];
      if (dsat_ff[ND] || qmag > ND'(OneQ28)) begin
         qmag = ND'(OneQ28);
      end
      ratio_c = dneg_ff[ND] ? -30'($signed({1'b0, qmag[28:0]})) - 30'(qmag[29] ? OneQ28 : 0)
                            : 30'($signed({1'b0, qmag[28:0]})) + 30'(qmag[29] ? OneQ28 : 0);
   end
   assign ratio_sq = square30(ratio_c);

   logic signed [29:0] y0c_ff;
   logic [56:0]        y0v_ff;
   cvec_type           y0a_ff, y0b_ff;
   logic signed [33:0] y0x_ff;
   logic               y0l_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         y0c_ff <= ratio_c;
         y0v_ff <= OneQ56 - ratio_sq[56:0];
         y0a_ff <= da_ff[ND];
         y0b_ff <= db_ff[ND];
         y0x_ff <= dc_ff[ND];
         y0l_ff <= dl_ff[ND];
      end
   end

   // ---------------- YS: sqrt(2^56 - ratio^2) for acos(ratio) ----------------
   localparam int NY = NQ;
   logic [56:0]        ysv_ff [NY+1];
   logic [NQ-1:0]      ysr_ff [NY+1];
   logic [NQ+1:0]      ysm_ff [NY+1];
   logic signed [29:0] ysc_ff [NY+1];
   cvec_type           ysa_ff [NY+1], ysb_ff [NY+1];
   logic signed [33:0] ysx_ff [NY+1];
   logic               ysl_ff [NY+1];

   always_comb begin
      ysv_ff[0] = y0v_ff;
      ysr_ff[0] = '0;
      ysm_ff[0] = '0;
      ysc_ff[0] = y0c_ff;
      ysa_ff[0] = y0a_ff;
      ysb_ff[0] = y0b_ff;
      ysx_ff[0] = y0x_ff;
      ysl_ff[0] = y0l_ff;
   end
   for (genvar s = 0; s < NY; s++) begin : g_ysq
      logic [57:0]   rad58;
      logic [NQ+1:0] rsh, tr;
      assign rad58 = {1'b0, ysv_ff[s]};
      assign rsh = {ysm_ff[s][NQ-1:0], rad58[57-2*s -: 2]};
      assign tr  = rsh - {ysr_ff[s], 2'b01};
      always_ff @(posedge clock) begin
         if (adv) begin
            ysv_ff[s+1] <= ysv_ff[s];
            ysm_ff[s+1] <= tr[NQ+1] ? rsh : tr;
            ysr_ff[s+1] <= {ysr_ff[s][NQ-2:0], !tr[NQ+1]};
            ysc_ff[s+1] <= ysc_ff[s];
            ysa_ff[s+1] <= ysa_ff[s];
            ysb_ff[s+1] <= ysb_ff[s];
            ysx_ff[s+1] <= ysx_ff[s];
            ysl_ff[s+1] <= ysl_ff[s];
         end
      end
   end
   assign ysq = ysr_ff[NY];

   always_ff @(posedge clock) begin
      if (adv) begin
         ya_ff <= ysa_ff[NY];
         yb_ff <= ysb_ff[NY];
         yy_ff <= cstart(ysc_ff[NY], ysq);
         yc_ff <= ysx_ff[NY];
         yl_ff <= ysl_ff[NY];
      end
   end

   // ---------------- C: CORDIC vectoring, three lanes ----------------
   cvec_type cv_ff [3][NC+1];
   logic signed [33:0] cc_ff [NC+1];
   logic               cl_ff [NC+1];
   always_comb begin
      cv_ff[0][0] = ya_ff;
      cv_ff[1][0] = yb_ff;
      cv_ff[2][0] = yy_ff;
      cc_ff[0]    = yc_ff;
      cl_ff[0]    = yl_ff;
   end
   for (genvar s = 0; s < NC; s++) begin : g_cordic
      for (genvar k = 0; k < 3; k++) begin : g_lane
         logic signed [31:0] dx, dy;
         assign dx = cv_ff[k][s].y >>> s;
         assign dy = cv_ff[k][s].x >>> s;
         always_ff @(posedge clock) begin
            if (adv) begin
               if (cv_ff[k][s].y > 0) begin
                  cv_ff[k][s+1].x <= cv_ff[k][s].x + dx;
                  cv_ff[k][s+1].y <= cv_ff[k][s].y - dy;
                  cv_ff[k][s+1].z <= cv_ff[k][s].z + atan_entry(4'(s));
               end else begin
                  cv_ff[k][s+1].x <= cv_ff[k][s].x - dx;
                  cv_ff[k][s+1].y <= cv_ff[k][s].y + dy;
                  cv_ff[k][s+1].z <= cv_ff[k][s].z - atan_entry(4'(s));
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            cc_ff[s+1] <= cc_ff[s];
            cl_ff[s+1] <= cl_ff[s];
         end
      end
   end

   function automatic logic signed [15:0] finish(input logic signed [19:0] z);
      logic signed [19:0] t;
      logic signed [19:0] r;
      t = z;
      if (t < 0) t = '0;
      if (t > PiQ16) t = PiQ16;
      r = (t + 20'sd4) >>> 3;
      return r[15:0];
   endfunction

   // ---------------- F: final ----------------
   rsp_type fo_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         fo_ff.roll_angle  <= finish(cv_ff[0][NC].z) - HalfPiQ13;
         fo_ff.pitch_angle <= finish(cv_ff[1][NC].z) - HalfPiQ13;
         if (cl_ff[NC]) begin
            fo_ff.yaw_angle <= '0;
         end else if (cc_ff[NC] > 0) begin
            fo_ff.yaw_angle <= -finish(cv_ff[2][NC].z);
         end else begin
            fo_ff.yaw_angle <= finish(cv_ff[2][NC].z);
         end
         fo_ff.gimbal_lock <= cl_ff[NC];
      end
   end

   localparam int Depth = 5 + NQ + 1 + ND + 1 + NY + 1 + NC + 1;
   logic [Depth-1:0] vv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff <= '0;
      end else if (adv) begin
         vv_ff <= {vv_ff[Depth-2:0], req_valid};
      end
   end
   assign pipe_out_v = vv_ff[Depth-1] && adv;
   assign pipe_out   = fo_ff;

   // ---------------- output queue ----------------
   logic pop;
   assign pop = (cnt_ff != 2'd0) && !rsp_stall;
   always_comb begin
      cnt_in = cnt_ff;
      if (pop) cnt_in = cnt_in - 2'd1;
      if (pipe_out_v) cnt_in = cnt_in + 2'd1;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
   always_ff @(posedge clock) begin
      // Drop head on pop; push tail with the arriving transfer.
      if (pop) begin
         if (pipe_out_v && cnt_ff == 2'd1) q0_ff <= pipe_out;
         else q0_ff <= q1_ff;
         if (pipe_out_v && cnt_ff == 2'd2) q1_ff <= pipe_out;
      end else if (pipe_out_v) begin
         if (cnt_ff == 2'd0) q0_ff <= pipe_out;
         else q1_ff <= pipe_out;
      end
   end
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_data  = q0_ff;

   // ---------------- assertions ----------------
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("output queue overflow");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && rsp_stall) |-> req_stall) else $error("stall not raised");
   a_lock_yaw: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.gimbal_lock) |-> rsp_data.yaw_angle == '0)
      else $error("yaw not zero in lock");

endmodule
